/* rtl/core/block_velocity_estimator_unit_macros.svh */
// assertion helpers used by the velocity estimator back end (bve_back)
`ifndef BLOCK_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define BLOCK_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BVE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BVE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bve_pkg.sv */
package bve_pkg;

   localparam logic [3:0]  GROUP_LENGTH_RESET = 4'd3;
   localparam logic [19:0] US_PER_S           = 20'd1000000;
   localparam logic [15:0] SPEED_MAX          = 16'hFFFF;

   // one finished group handed from the front to the divider
   typedef struct packed {
      logic [15:0] dist_diff;
      logic [31:0] time_diff;
      logic [31:0] interval_start;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MULT,
      BK_CHECK,
      BK_DIVIDE,
      BK_HOLD
   } back_state_type;

endpackage

/* rtl/core/bve_front.sv */
module bve_front
   import bve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_time_us,
   input  logic [15:0] req_distance_mm,
   input  logic        req_restart,
   input  logic        queue_full,
   output logic        queue_push,
   output job_type     queue_job
);

   logic [3:0]  group_length_ff;
   logic [15:0] anchor_dist_ff, anchor_dist_in;
   logic [31:0] anchor_time_ff, anchor_time_in;
   logic [31:0] run_start_ff, run_start_in;
   logic [3:0]  steps_ff, steps_in;
   logic        active_ff, active_in;

   logic        accept;
   logic [3:0]  len_eff;
   logic [3:0]  steps_next;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !req_stall;
   assign len_eff    = (group_length_ff == 4'd0) ? 4'd1 : group_length_ff;
   assign steps_next = steps_ff + 4'd1;

   always_comb begin
      anchor_dist_in = anchor_dist_ff;
      anchor_time_in = anchor_time_ff;
      run_start_in   = run_start_ff;
      steps_in       = steps_ff;
      active_in      = active_ff;
      queue_push     = 1'b0;
      queue_job.dist_diff = (req_distance_mm >= anchor_dist_ff) ?
                            req_distance_mm - anchor_dist_ff :
                            anchor_dist_ff - req_distance_mm;
      queue_job.time_diff      = req_sample_time_us - anchor_time_ff;
      queue_job.interval_start = anchor_time_ff - run_start_ff;
      if (accept) begin
         if (!active_ff || req_restart) begin
            run_start_in   = req_sample_time_us;
            anchor_time_in = req_sample_time_us;
            anchor_dist_in = req_distance_mm;
            steps_in       = 4'd0;
            active_in      = 1'b1;
         end else if (steps_next >= len_eff) begin
            // group complete: hand it on and re-anchor here
            queue_push     = 1'b1;
            anchor_time_in = req_sample_time_us;
            anchor_dist_in = req_distance_mm;
            steps_in       = 4'd0;
         end else begin
            steps_in = steps_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_length_ff <= GROUP_LENGTH_RESET;
         anchor_dist_ff  <= '0;
         anchor_time_ff  <= '0;
         run_start_ff    <= '0;
         steps_ff        <= '0;
         active_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            group_length_ff <= csr_wr_data;
         end
         anchor_dist_ff <= anchor_dist_in;
         anchor_time_ff <= anchor_time_in;
         run_start_ff   <= run_start_in;
         steps_ff       <= steps_in;
         active_ff      <= active_in;
      end
   end

endmodule

/* rtl/core/bve_queue.sv */
module bve_queue
   import bve_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   output logic    head_valid,
   input  logic    pop,
   output job_type head_job
);

   job_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;
   logic        do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/core/bve_back.sv */
`include "block_velocity_estimator_unit_macros.svh"

module bve_back
   import bve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_speed_mm_per_s,
   output logic [31:0] rsp_interval_start_us,
   output logic        rsp_zero_time_flag,
   output logic        rsp_saturated_flag
);

   back_state_type state_ff, state_in;
   logic [15:0] dd_ff, dd_in;
   logic [31:0] dt_ff, dt_in;
   logic [31:0] ivl_ff, ivl_in;
   logic [35:0] num_ff, num_in;
   logic [47:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [15:0] quo_ff, quo_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        zero_ff, zero_in;
   logic        sat_ff, sat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_speed_ff, rsp_speed_in;
   logic [31:0] rsp_ivl_ff, rsp_ivl_in;
   logic        rsp_zero_ff, rsp_zero_in;
   logic        rsp_sat_ff, rsp_sat_in;

   always_comb begin
      state_in     = state_ff;
      dd_in        = dd_ff;
      dt_in        = dt_ff;
      ivl_in       = ivl_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_speed_in = rsp_speed_ff;
      rsp_ivl_in   = rsp_ivl_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_sat_in   = rsp_sat_ff;
      job_pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               dd_in    = job.dist_diff;
               dt_in    = job.time_diff;
               ivl_in   = job.interval_start;
               state_in = BK_MULT;
            end
         end
         BK_MULT: begin
            num_in   = dd_ff * US_PER_S;
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            zero_in = 1'b0;
            sat_in  = 1'b0;
            quo_in  = '0;
            if (dt_ff == 32'd0) begin
               zero_in  = 1'b1;
               quo_in   = SPEED_MAX;
               state_in = BK_HOLD;
            end else if ({12'd0, num_ff} >= {dt_ff, 16'd0}) begin
               // quotient would need more than 16 bits
               sat_in   = 1'b1;
               quo_in   = SPEED_MAX;
               state_in = BK_HOLD;
            end else begin
               rem_in   = {12'd0, num_ff};
               den_in   = {1'b0, dt_ff, 15'd0};
               cnt_in   = 4'd15;
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            // restoring division, one quotient bit per cycle, msb first
            if (rem_ff >= den_ff) begin
               rem_in = rem_ff - den_ff;
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               quo_in = {quo_ff[14:0], 1'b0};
            end
            den_in = den_ff >> 1;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = quo_ff;
               rsp_ivl_in   = ivl_ff;
               rsp_zero_in  = zero_ff;
               rsp_sat_in   = sat_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dd_ff        <= dd_in;
      dt_ff        <= dt_in;
      ivl_ff       <= ivl_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_ivl_ff   <= rsp_ivl_in;
      rsp_zero_ff  <= rsp_zero_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_speed_mm_per_s    = rsp_speed_ff;
   assign rsp_interval_start_us = rsp_ivl_ff;
   assign rsp_zero_time_flag    = rsp_zero_ff;
   assign rsp_saturated_flag    = rsp_sat_ff;

   `BVE_ASSERT_SAME(flags_exclusive, rsp_valid_ff, !(rsp_zero_ff && rsp_sat_ff), "both flags set")
   `BVE_ASSERT_SAME(flag_means_max, rsp_valid_ff && (rsp_zero_ff || rsp_sat_ff), rsp_speed_ff == SPEED_MAX, "flagged speed not clamped")
   `BVE_ASSERT_NEXT(divide_ends, (state_ff == BK_DIVIDE) && (cnt_ff == 4'd0), state_ff == BK_HOLD, "divider did not finish")
   `BVE_ASSERT_NEXT(hold_delivers, (state_ff == BK_HOLD) && (!rsp_valid_ff || !rsp_stall), rsp_valid_ff && (state_ff == BK_IDLE), "result not loaded")

endmodule

/* rtl/core/block_velocity_estimator_unit.sv */
// path of a group-completing item to its result: queue hand-off, multiply, range check,
// 16 divide steps, output load; the divide steps are skipped for a zero time span or a
// saturating speed, and the output load waits while a held result is stalled
// the back end takes a new group from the queue only once the last result is loaded;
// items that finish no group are taken every cycle while the queue has room
// reset: synchronous, active high; clears run state, queue, output valid; group_length 3
module block_velocity_estimator_unit
   import bve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_sample_time_us,
   input  logic [15:0] req_distance_mm,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_speed_mm_per_s,
   output logic [31:0] rsp_interval_start_us,
   output logic        rsp_zero_time_flag,
   output logic        rsp_saturated_flag
);

   logic    queue_full;
   logic    queue_push;
   job_type push_job;
   logic    head_valid;
   logic    head_pop;
   job_type head_job;

   bve_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_time_us (req_sample_time_us),
      .req_distance_mm    (req_distance_mm),
      .req_restart        (req_restart),
      .queue_full         (queue_full),
      .queue_push         (queue_push),
      .queue_job          (push_job)
   );

   bve_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_job   (push_job),
      .full       (queue_full),
      .head_valid (head_valid),
      .pop        (head_pop),
      .head_job   (head_job)
   );

   bve_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .job_valid             (head_valid),
      .job                   (head_job),
      .job_pop               (head_pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_speed_mm_per_s    (rsp_speed_mm_per_s),
      .rsp_interval_start_us (rsp_interval_start_us),
      .rsp_zero_time_flag    (rsp_zero_time_flag),
      .rsp_saturated_flag    (rsp_saturated_flag)
   );

endmodule
